// ===== rtl/core/dbe_pkg.sv =====
`default_nettype none
package dbe_pkg;

    localparam int CODE_BYTES_DEF = 256;

    localparam logic [1:0] OPN_CLEAR = 2'd0;
    localparam logic [1:0] OPN_WRITE = 2'd1;
    localparam logic [1:0] OPN_RUN   = 2'd2;
    localparam logic [1:0] OPN_READ  = 2'd3;

    localparam logic [7:0] OC_SENSE = 8'd160;
    localparam logic [7:0] OC_ZO    = 8'd161;
    localparam logic [7:0] OC_ZERO  = 8'd162;
    localparam logic [7:0] OC_M45   = 8'd176;
    localparam logic [7:0] OC_M78   = 8'd177;
    localparam logic [7:0] OC_LED   = 8'd178;
    localparam logic [7:0] OC_SLL   = 8'd179;
    localparam logic [7:0] OC_SRL   = 8'd180;
    localparam logic [7:0] OC_SLC   = 8'd181;
    localparam logic [7:0] OC_SRC   = 8'd182;
    localparam logic [7:0] OC_ADD   = 8'd224;
    localparam logic [7:0] OC_SUB   = 8'd225;
    localparam logic [7:0] OC_MUL   = 8'd226;
    localparam logic [7:0] OC_DIV   = 8'd227;
    localparam logic [7:0] OC_MAX   = 8'd228;
    localparam logic [7:0] OC_MIN   = 8'd229;
    localparam logic [7:0] OC_LATCH = 8'd230;
    localparam logic [7:0] OC_CMP   = 8'd231;
    localparam logic [7:0] OC_AND   = 8'd232;
    localparam logic [7:0] OC_OR    = 8'd233;
    localparam logic [7:0] OC_NOT   = 8'd234;
    localparam logic [7:0] OC_SEL   = 8'd235;
    localparam logic [7:0] OC_CONST = 8'd255;

    localparam logic [2:0] K_RD  = 3'd0;
    localparam logic [2:0] K_WR  = 3'd1;
    localparam logic [2:0] K_MUL = 3'd2;
    localparam logic [2:0] K_DIV = 3'd3;
    localparam logic [2:0] K_AVG = 3'd4;
    localparam logic [2:0] K_PIN = 3'd5;
    localparam logic [2:0] K_END = 3'd6;

    localparam logic [1:0] SL_X = 2'd0;
    localparam logic [1:0] SL_Y = 2'd1;
    localparam logic [1:0] SL_Z = 2'd2;
    localparam logic [1:0] SL_W = 2'd3;

    localparam logic [2:0] C_AL      = 3'd0;
    localparam logic [2:0] C_NE      = 3'd1;
    localparam logic [2:0] C_EQ      = 3'd2;
    localparam logic [2:0] C_EQZ0    = 3'd3;
    localparam logic [2:0] C_EQZN    = 3'd4;
    localparam logic [2:0] C_EQZNW0  = 3'd5;

    localparam logic [4:0] V_ZERO  = 5'd0;
    localparam logic [4:0] V_ONE   = 5'd1;
    localparam logic [4:0] V_Q     = 5'd2;
    localparam logic [4:0] V_ADD   = 5'd3;
    localparam logic [4:0] V_SUB   = 5'd4;
    localparam logic [4:0] V_DIVR  = 5'd5;
    localparam logic [4:0] V_MAX   = 5'd6;
    localparam logic [4:0] V_MIN   = 5'd7;
    localparam logic [4:0] V_LATC  = 5'd8;
    localparam logic [4:0] V_LATD  = 5'd9;
    localparam logic [4:0] V_H     = 5'd10;
    localparam logic [4:0] V_LT    = 5'd11;
    localparam logic [4:0] V_EQ    = 5'd12;
    localparam logic [4:0] V_GT    = 5'd13;
    localparam logic [4:0] V_AND   = 5'd14;
    localparam logic [4:0] V_OR    = 5'd15;
    localparam logic [4:0] V_NOT   = 5'd16;
    localparam logic [4:0] V_SEL   = 5'd17;
    localparam logic [4:0] V_CONST = 5'd18;

    localparam logic [2:0] DS_AVG4 = 3'd0;
    localparam logic [2:0] DS_AVG  = 3'd1;
    localparam logic [2:0] DS_MUL  = 3'd2;
    localparam logic [2:0] DS_DIV  = 3'd3;

    localparam logic [1:0] DM_SERIAL = 2'd0;
    localparam logic [1:0] DM_BY5    = 2'd1;
    localparam logic [1:0] DM_BY100  = 2'd2;

    // ceil(2^22 / 5) and ceil(2^37 / 100)
    localparam logic [30:0] RECIP5   = 31'd838861;
    localparam logic [30:0] RECIP100 = 31'd1374389535;

    localparam logic [2:0] MS_XY   = 3'd0;
    localparam logic [2:0] MS_X100 = 3'd1;

    localparam logic [2:0] P_M45 = 3'd0;
    localparam logic [2:0] P_M78 = 3'd1;
    localparam logic [2:0] P_LED = 3'd2;
    localparam logic [2:0] P_SLL = 3'd3;
    localparam logic [2:0] P_SRL = 3'd4;
    localparam logic [2:0] P_SLC = 3'd5;
    localparam logic [2:0] P_SRC = 3'd6;

    localparam logic [4:0] LEFT_PINS  [4] = '{5'd13, 5'd14, 5'd15, 5'd12};
    localparam logic [4:0] RIGHT_PINS [4] = '{5'd0, 5'd5, 5'd4, 5'd2};

    localparam logic [15:0] SENSOR_DIV = 16'd5;
    localparam logic [15:0] SCALE      = 16'd100;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] opnd;
        logic [1:0] slot;
        logic [4:0] val;
        logic [2:0] cond;
        logic [2:0] sel;
    } t_uop;

    typedef struct packed {
        logic        start;
        logic [1:0]  mode;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    function automatic t_uop u_rd(input logic [2:0] o, input logic [1:0] s,
                                  input logic [2:0] c);
        u_rd = '{kind: K_RD, opnd: o, slot: s, val: V_ZERO, cond: c, sel: 3'd0};
    endfunction

    function automatic t_uop u_wr(input logic [2:0] o, input logic [4:0] v,
                                  input logic [2:0] c);
        u_wr = '{kind: K_WR, opnd: o, slot: SL_X, val: v, cond: c, sel: 3'd0};
    endfunction

    function automatic t_uop u_ex(input logic [2:0] k, input logic [2:0] s);
        u_ex = '{kind: k, opnd: 3'd0, slot: SL_X, val: V_ZERO, cond: C_AL, sel: s};
    endfunction

    function automatic t_uop uop_body(input logic [7:0] op, input logic [3:0] st);
        t_uop u;
        u = u_ex(K_END, 3'd0);
        case (op)
            OC_SENSE: begin
                case (st)
                    4'd0: u = u_ex(K_DIV, DS_AVG4);
                    4'd1: u = u_ex(K_AVG, 3'd0);
                    4'd2: u = u_ex(K_DIV, DS_AVG);
                    4'd3: u = u_wr(3'd1, V_Q, C_AL);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_ZO: begin
                case (st)
                    4'd0: u = u_wr(3'd1, V_ZERO, C_AL);
                    4'd1: u = u_wr(3'd2, V_ONE, C_AL);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_ZERO: begin
                if (st == 4'd0) u = u_wr(3'd1, V_ZERO, C_AL);
            end
            OC_M45, OC_M78, OC_SLL, OC_SRL: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: begin
                        case (op)
                            OC_M45: u = u_ex(K_PIN, P_M45);
                            OC_M78: u = u_ex(K_PIN, P_M78);
                            OC_SLL: u = u_ex(K_PIN, P_SLL);
                            default: u = u_ex(K_PIN, P_SRL);
                        endcase
                    end
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_LED: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: u = u_rd(3'd3, SL_Y, C_AL);
                    4'd2: u = u_ex(K_PIN, P_LED);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_SLC, OC_SRC: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: u = u_rd(3'd2, SL_Y, C_AL);
                    4'd2: u = u_ex(K_PIN, (op == OC_SLC) ? P_SLC : P_SRC);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_ADD, OC_SUB, OC_MAX, OC_MIN, OC_AND, OC_OR: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: u = u_rd(3'd2, SL_Y, C_AL);
                    4'd2: begin
                        case (op)
                            OC_ADD: u = u_wr(3'd3, V_ADD, C_AL);
                            OC_SUB: u = u_wr(3'd3, V_SUB, C_AL);
                            OC_MAX: u = u_wr(3'd3, V_MAX, C_AL);
                            OC_MIN: u = u_wr(3'd3, V_MIN, C_AL);
                            OC_AND: u = u_wr(3'd3, V_AND, C_AL);
                            default: u = u_wr(3'd3, V_OR, C_AL);
                        endcase
                    end
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_MUL, OC_DIV: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: u = u_rd(3'd2, SL_Y, C_AL);
                    4'd2: u = u_ex(K_MUL, (op == OC_MUL) ? MS_XY : MS_X100);
                    4'd3: u = u_ex(K_DIV, (op == OC_MUL) ? DS_MUL : DS_DIV);
                    4'd4: u = u_wr(3'd3, (op == OC_MUL) ? V_Q : V_DIVR, C_AL);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_LATCH: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: u = u_rd(3'd2, SL_Y, C_AL);
                    4'd2: u = u_wr(3'd3, V_LATC, C_NE);
                    4'd3: u = u_wr(3'd4, V_LATD, C_NE);
                    4'd4: u = u_rd(3'd3, SL_Z, C_EQ);
                    4'd5: u = u_wr(3'd4, V_H, C_EQZ0);
                    4'd6: u = u_rd(3'd4, SL_W, C_EQZN);
                    4'd7: u = u_wr(3'd3, V_H, C_EQZNW0);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_CMP: begin
                case (st)
                    4'd0, 4'd3, 4'd6: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1, 4'd4, 4'd7: u = u_rd(3'd2, SL_Y, C_AL);
                    4'd2: u = u_wr(3'd3, V_LT, C_AL);
                    4'd5: u = u_wr(3'd4, V_EQ, C_AL);
                    4'd8: u = u_wr(3'd5, V_GT, C_AL);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_NOT: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: u = u_wr(3'd2, V_NOT, C_AL);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_SEL: begin
                case (st)
                    4'd0: u = u_rd(3'd1, SL_X, C_AL);
                    4'd1: u = u_rd(3'd2, SL_Y, C_AL);
                    4'd2: u = u_rd(3'd3, SL_Z, C_AL);
                    4'd3: u = u_wr(3'd4, V_SEL, C_AL);
                    default: u = u_ex(K_END, 3'd0);
                endcase
            end
            OC_CONST: begin
                if (st == 4'd0) u = u_wr(3'd3, V_CONST, C_AL);
            end
            default: u = u_ex(K_END, 3'd0);
        endcase
        return u;
    endfunction

    function automatic logic [3:0] op_len(input logic [7:0] op);
        case (op)
            OC_SENSE, OC_ZERO, OC_M45, OC_M78, OC_SLL, OC_SRL: op_len = 4'd2;
            OC_ZO, OC_SLC, OC_SRC, OC_NOT: op_len = 4'd3;
            OC_LATCH, OC_SEL: op_len = 4'd5;
            OC_CMP: op_len = 4'd6;
            default: op_len = 4'd4;
        endcase
    endfunction

    function automatic logic op_known(input logic [7:0] op);
        case (op)
            OC_SENSE, OC_ZO, OC_ZERO, OC_M45, OC_M78, OC_LED, OC_SLL, OC_SRL,
            OC_SLC, OC_SRC, OC_ADD, OC_SUB, OC_MUL, OC_DIV, OC_MAX, OC_MIN,
            OC_LATCH, OC_CMP, OC_AND, OC_OR, OC_NOT, OC_SEL, OC_CONST:
                op_known = 1'b1;
            default: op_known = 1'b0;
        endcase
    endfunction

    function automatic logic [3:0] half_step(input logic [2:0] ph);
        case (ph)
            3'd0: half_step = 4'd8;
            3'd1: half_step = 4'd12;
            3'd2: half_step = 4'd4;
            3'd3: half_step = 4'd6;
            3'd4: half_step = 4'd2;
            3'd5: half_step = 4'd3;
            3'd6: half_step = 4'd1;
            default: half_step = 4'd9;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dbe_if.sv =====
`default_nettype none
interface dbe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] address;
    logic [7:0] code_value;
    logic [9:0] adc_sample;
    modport source (output valid, operation, address, code_value, adc_sample, input ready);
    modport sink   (input valid, operation, address, code_value, adc_sample, output ready);
endinterface

interface dbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] port_value;
    logic [16:0]        pin_vector;
    logic               stop_cause;
    logic               divide_fault;
    modport source (output valid, port_value, pin_vector, stop_cause, divide_fault,
                    input ready);
    modport sink   (input valid, port_value, pin_vector, stop_cause, divide_fault,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dataflow_bytecode_executor_unit.sv =====
`default_nettype none
// Bytecode executor over a code memory of CODE_BYTES bytes and a 256-entry port
// memory. Each transfer on i_in is one operation and yields one transfer on
// o_out. After reset, and for every clear operation, a sweep zeroes both
// memories; no operation is taken during the reset sweep. A run fetches each
// opcode and five operand bytes from the code memory, then walks a micro-step
// list of port reads, port writes, multiplies, divisions by a constant (two in
// each sensor read, one in each multiply) and the radix-2 divider of the divide
// opcode, and then clears port 0 and advances. A pass stops early on an unknown
// opcode.
module dataflow_bytecode_executor_unit #(
    parameter int CODE_BYTES = dbe_pkg::CODE_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dbe_in_if.sink    i_in,
    dbe_out_if.source o_out
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RDP   = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_RDW   = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_PCHK  = 4'd9;

    localparam logic [8:0] CB = 9'(CODE_BYTES);

    logic [3:0]         r_state;
    logic [7:0]         r_clr;
    logic               r_clrop;
    logic [8:0]         r_pc;
    logic [2:0]         r_f;
    logic               r_oobd;
    logic [7:0]         r_byte [6];
    logic [3:0]         r_step;
    logic               r_zdone;
    logic signed [15:0] r_x, r_y, r_z, r_w;
    logic signed [31:0] r_prod;
    logic [15:0]        r_q;
    logic [15:0]        r_avg;
    logic [9:0]         r_adc;
    logic [2:0]         r_lph, r_rph;
    logic [16:0]        r_pins;
    logic               r_stop, r_fault;
    logic [15:0]        r_rpv;
    logic               r_ovalid;
    logic [15:0]        r_opv;
    logic [16:0]        r_opins;
    logic               r_ostop, r_ofault;

    logic               n_acc;
    dbe_pkg::t_uop      n_u;
    logic [7:0]         n_uaddr;
    logic               n_cok;
    logic [15:0]        n_val;
    logic [8:0]         n_fa;
    logic               n_oob;
    logic               cm_we, pm_we;
    logic [7:0]         cm_addr, pm_addr, cm_wd, cm_rd;
    logic [15:0]        pm_wd, pm_rd;
    logic [11:0]        n_rng;
    dbe_pkg::t_div_req  n_dreq;
    logic               div_done;
    logic [31:0]        div_q;
    logic               n_left, n_up, n_dn;
    logic [2:0]         n_ph;
    logic [3:0]         n_pat;

    assign i_in.ready = (r_state == S_IDLE);
    assign n_acc      = i_in.valid && (r_state == S_IDLE);

    assign n_u     = dbe_pkg::uop_body(r_byte[0], r_step);
    assign n_uaddr = (n_u.opnd == 3'd0) ? 8'd0 : r_byte[n_u.opnd];
    assign n_fa    = r_pc + 9'(r_f);
    assign n_oob   = (n_fa >= CB);

    always_comb begin
        case (n_u.cond)
            dbe_pkg::C_AL:     n_cok = 1'b1;
            dbe_pkg::C_NE:     n_cok = (r_x != r_y);
            dbe_pkg::C_EQ:     n_cok = (r_x == r_y);
            dbe_pkg::C_EQZ0:   n_cok = (r_x == r_y) && (r_z == 16'sd0);
            dbe_pkg::C_EQZN:   n_cok = (r_x == r_y) && (r_z != 16'sd0);
            dbe_pkg::C_EQZNW0: n_cok = (r_x == r_y) && (r_z != 16'sd0) && (r_w == 16'sd0);
            default:           n_cok = 1'b0;
        endcase
    end

    always_comb begin
        case (n_u.val)
            dbe_pkg::V_ONE:   n_val = 16'd1;
            dbe_pkg::V_Q:     n_val = r_q;
            dbe_pkg::V_ADD:   n_val = r_x + r_y;
            dbe_pkg::V_SUB:   n_val = r_x - r_y;
            dbe_pkg::V_DIVR:  n_val = (r_y == 16'sd0) ? 16'd0 : r_q;
            dbe_pkg::V_MAX:   n_val = (r_x > r_y) ? r_x : r_y;
            dbe_pkg::V_MIN:   n_val = (r_x < r_y) ? r_x : r_y;
            dbe_pkg::V_LATC:  n_val = (r_x > r_y) ? dbe_pkg::SCALE : 16'd0;
            dbe_pkg::V_LATD:  n_val = (r_x > r_y) ? 16'd0 : dbe_pkg::SCALE;
            dbe_pkg::V_H:     n_val = dbe_pkg::SCALE;
            dbe_pkg::V_LT:    n_val = {15'd0, r_x < r_y};
            dbe_pkg::V_EQ:    n_val = {15'd0, r_x == r_y};
            dbe_pkg::V_GT:    n_val = {15'd0, r_x > r_y};
            dbe_pkg::V_AND:   n_val = {15'd0, (r_x != 16'sd0) && (r_y != 16'sd0)};
            dbe_pkg::V_OR:    n_val = {15'd0, (r_x != 16'sd0) || (r_y != 16'sd0)};
            dbe_pkg::V_NOT:   n_val = {15'd0, r_x == 16'sd0};
            dbe_pkg::V_SEL:   n_val = (r_x != 16'sd0) ? r_y : r_z;
            dbe_pkg::V_CONST: n_val = {r_byte[1], r_byte[2]};
            default:          n_val = 16'd0;
        endcase
    end

    always_comb begin
        if (r_adc < 10'd100) begin
            n_rng = 12'd3000;
        end else if (r_adc > 10'd400) begin
            n_rng = 12'd300;
        end else begin
            n_rng = 12'd3000 - (({2'b00, r_adc} - 12'd100) * 12'd9);
        end
    end

    always_comb begin
        n_dreq.start = (r_state == S_STEP) && (n_u.kind == dbe_pkg::K_DIV);
        case (n_u.sel)
            dbe_pkg::DS_AVG4: begin
                n_dreq.mode     = dbe_pkg::DM_BY5;
                n_dreq.dividend = {14'd0, r_avg, 2'b00};
                n_dreq.divisor  = dbe_pkg::SENSOR_DIV;
            end
            dbe_pkg::DS_AVG: begin
                n_dreq.mode     = dbe_pkg::DM_BY5;
                n_dreq.dividend = {16'd0, r_avg};
                n_dreq.divisor  = dbe_pkg::SENSOR_DIV;
            end
            dbe_pkg::DS_MUL: begin
                n_dreq.mode     = dbe_pkg::DM_BY100;
                n_dreq.dividend = r_prod;
                n_dreq.divisor  = dbe_pkg::SCALE;
            end
            default: begin
                n_dreq.mode     = dbe_pkg::DM_SERIAL;
                n_dreq.dividend = r_prod;
                n_dreq.divisor  = r_y;
            end
        endcase
    end

    always_comb begin
        n_left = (n_u.sel == dbe_pkg::P_SLL) || (n_u.sel == dbe_pkg::P_SLC);
        if ((n_u.sel == dbe_pkg::P_SLL) || (n_u.sel == dbe_pkg::P_SRL)) begin
            n_up = (r_x > 16'sd100);
            n_dn = (r_x < -16'sd100);
        end else begin
            n_up = (r_x > r_y);
            n_dn = (r_x < r_y);
        end
        n_ph = n_left ? r_lph : r_rph;
        if (n_up) n_ph = n_ph + 3'd1;
        else if (n_dn) n_ph = n_ph - 3'd1;
        n_pat = (n_up || n_dn) ? dbe_pkg::half_step(n_ph) : 4'd0;
    end

    always_comb begin
        cm_we   = 1'b0;
        cm_addr = n_fa[7:0];
        cm_wd   = 8'd0;
        pm_we   = 1'b0;
        pm_addr = n_uaddr;
        pm_wd   = n_val;
        case (r_state)
            S_CLR: begin
                cm_we   = ({1'b0, r_clr} < CB);
                cm_addr = r_clr;
                pm_we   = 1'b1;
                pm_addr = r_clr;
                pm_wd   = 16'd0;
            end
            S_IDLE: begin
                cm_addr = i_in.address;
                cm_wd   = i_in.code_value;
                cm_we   = n_acc && (i_in.operation == dbe_pkg::OPN_WRITE)
                          && ({1'b0, i_in.address} < CB);
                pm_addr = i_in.address;
            end
            S_STEP: begin
                if (n_u.kind == dbe_pkg::K_WR) begin
                    pm_we = n_cok;
                end else if (n_u.kind == dbe_pkg::K_END) begin
                    pm_we   = !r_zdone;
                    pm_addr = 8'd0;
                    pm_wd   = 16'd0;
                end
            end
            default: begin
                cm_we = 1'b0;
            end
        endcase
    end

    dbe_ram #(.DEPTH(CODE_BYTES), .DW(8)) u_code (
        .i_clk(i_clk), .i_we(cm_we), .i_addr(cm_addr), .i_wdata(cm_wd), .o_rdata(cm_rd)
    );

    dbe_ram #(.DEPTH(256), .DW(16)) u_port (
        .i_clk(i_clk), .i_we(pm_we), .i_addr(pm_addr), .i_wdata(pm_wd), .o_rdata(pm_rd)
    );

    dbe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_dreq), .o_done(div_done), .o_quot(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= 8'd0;
            r_clrop  <= 1'b0;
            r_avg    <= 16'd0;
            r_lph    <= 3'd0;
            r_rph    <= 3'd0;
            r_pins   <= 17'd0;
            r_ovalid <= 1'b0;
            r_stop   <= 1'b0;
            r_fault  <= 1'b0;
            r_pc     <= 9'd0;
            r_f      <= 3'd0;
            r_step   <= 4'd0;
            r_zdone  <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready && (r_state != S_DONE)) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 8'd1;
                    if (r_clr == 8'd255) begin
                        r_state <= r_clrop ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_rpv   <= 16'd0;
                    r_stop  <= 1'b0;
                    r_fault <= 1'b0;
                    if (n_acc) begin
                        case (i_in.operation)
                            dbe_pkg::OPN_CLEAR: begin
                                r_clr   <= 8'd0;
                                r_clrop <= 1'b1;
                                r_state <= S_CLR;
                            end
                            dbe_pkg::OPN_WRITE: r_state <= S_DONE;
                            dbe_pkg::OPN_RUN: begin
                                r_adc   <= i_in.adc_sample;
                                r_pc    <= 9'd0;
                                r_state <= S_PCHK;
                            end
                            default: r_state <= S_RDP;
                        endcase
                    end
                end
                S_RDP: begin
                    r_rpv   <= pm_rd;
                    r_state <= S_DONE;
                end
                S_PCHK: begin
                    r_f     <= 3'd0;
                    r_state <= (r_pc < CB) ? S_FETCH : S_DONE;
                end
                S_FETCH: begin
                    r_oobd <= n_oob;
                    if (r_f != 3'd0) begin
                        r_byte[3'(r_f - 3'd1)] <= r_oobd ? 8'd0 : cm_rd;
                    end
                    r_f <= r_f + 3'd1;
                    if (r_f == 3'd6) r_state <= S_DEC;
                end
                S_DEC: begin
                    r_step  <= 4'd0;
                    r_zdone <= 1'b0;
                    if (dbe_pkg::op_known(r_byte[0])) begin
                        r_state <= S_STEP;
                    end else begin
                        r_stop  <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_STEP: begin
                    case (n_u.kind)
                        dbe_pkg::K_RD: begin
                            r_state <= n_cok ? S_RDW : S_STEP;
                            if (!n_cok) r_step <= r_step + 4'd1;
                        end
                        dbe_pkg::K_WR: begin
                            if (n_cok && (n_u.val == dbe_pkg::V_DIVR) && (r_y == 16'sd0)) begin
                                r_fault <= 1'b1;
                            end
                            r_step <= r_step + 4'd1;
                        end
                        dbe_pkg::K_MUL: begin
                            r_prod <= (n_u.sel == dbe_pkg::MS_XY) ? (r_x * r_y)
                                                                 : (r_x * 32'sd100);
                            r_step <= r_step + 4'd1;
                        end
                        dbe_pkg::K_DIV: r_state <= S_DIVW;
                        dbe_pkg::K_AVG: begin
                            r_avg  <= r_q + {4'd0, n_rng};
                            r_step <= r_step + 4'd1;
                        end
                        dbe_pkg::K_PIN: begin
                            case (n_u.sel)
                                dbe_pkg::P_M45: begin
                                    r_pins[4] <= (r_x >= 16'sd100);
                                    r_pins[5] <= (r_x <= -16'sd100);
                                end
                                dbe_pkg::P_M78: begin
                                    r_pins[7] <= (r_x >= 16'sd100);
                                    r_pins[8] <= (r_x <= -16'sd100);
                                end
                                dbe_pkg::P_LED: begin
                                    r_pins[16] <= (r_x <= 16'sd0);
                                    r_pins[2]  <= (r_y <= 16'sd0);
                                end
                                default: begin
                                    if (n_left) r_lph <= n_ph;
                                    else r_rph <= n_ph;
                                    for (int k = 0; k < 4; k++) begin
                                        r_pins[n_left ? dbe_pkg::LEFT_PINS[k]
                                                      : dbe_pkg::RIGHT_PINS[k]] <= n_pat[3-k];
                                    end
                                end
                            endcase
                            r_step <= r_step + 4'd1;
                        end
                        default: begin
                            if (!r_zdone) begin
                                r_zdone <= 1'b1;
                            end else begin
                                r_pc    <= r_pc + {5'd0, dbe_pkg::op_len(r_byte[0])};
                                r_state <= S_PCHK;
                            end
                        end
                    endcase
                end
                S_RDW: begin
                    case (n_u.slot)
                        dbe_pkg::SL_X: r_x <= pm_rd;
                        dbe_pkg::SL_Y: r_y <= pm_rd;
                        dbe_pkg::SL_Z: r_z <= pm_rd;
                        default:       r_w <= pm_rd;
                    endcase
                    r_step  <= r_step + 4'd1;
                    r_state <= S_STEP;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_q     <= div_q[15:0];
                        r_step  <= r_step + 4'd1;
                        r_state <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_opv    <= r_rpv;
                        r_opins  <= r_pins;
                        r_ostop  <= r_stop;
                        r_ofault <= r_fault;
                        r_clrop  <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.port_value   = r_opv;
    assign o_out.pin_vector   = r_opins;
    assign o_out.stop_cause   = r_ostop;
    assign o_out.divide_fault = r_ofault;
endmodule
`default_nettype wire

// ===== rtl/core/dbe_ram.sv =====
`default_nettype none
module dbe_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [7:0]    i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr[IW-1:0]] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr[IW-1:0]];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/core/dbe_div.sv =====
`default_nettype none
module dbe_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dbe_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [31:0]            o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [1:0]  r_mode;
    logic [16:0] r_rem;
    logic [31:0] r_dvd;
    logic [16:0] r_dsr;
    logic        r_neg;
    logic [61:0] r_prd;

    logic [31:0] n_mag;
    logic [16:0] n_dsx;
    logic [16:0] n_sh;
    logic        n_ge;
    logic [16:0] n_rem;
    logic [30:0] n_k;
    logic [31:0] n_cq;

    always_comb begin
        n_mag = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
        n_dsx = {i_req.divisor[15], i_req.divisor};
        if (n_dsx[16]) n_dsx = 17'd0 - n_dsx;
        n_sh  = {r_rem[15:0], r_dvd[31]};
        n_ge  = (n_sh >= r_dsr);
        n_rem = n_ge ? (n_sh - r_dsr) : n_sh;
        n_k   = (r_mode == dbe_pkg::DM_BY5) ? dbe_pkg::RECIP5 : dbe_pkg::RECIP100;
        n_cq  = (r_mode == dbe_pkg::DM_BY5) ? r_prd[53:22] : {7'd0, r_prd[61:37]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_mode <= i_req.mode;
                r_rem  <= 17'd0;
                r_dvd  <= n_mag;
                r_dsr  <= n_dsx;
                r_neg  <= i_req.dividend[31] ^ i_req.divisor[15];
            end else if (r_busy && (r_mode != dbe_pkg::DM_SERIAL)) begin
                // constant divisor: reciprocal multiply, then shift
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd0) begin
                    r_prd <= 62'(r_dvd[30:0]) * 62'(n_k);
                end else begin
                    r_dvd  <= n_cq;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[30:0], n_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_dvd) : r_dvd;
endmodule
`default_nettype wire
